### hdl/kmer_histogram_cosine_similarity_defines.svh
// assertion macros used by the controller
`ifndef KMER_HISTOGRAM_COSINE_SIMILARITY_DEFINES_SVH
`define KMER_HISTOGRAM_COSINE_SIMILARITY_DEFINES_SVH
`ifndef NO_ASSERTIONS
// condition holds at every clock edge out of reset
`define KHC_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// antecedent at one edge implies consequent at the next edge
`define KHC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KHC_ASSERT_ALWAYS(name, cond)
`define KHC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

### hdl/khc_pkg.sv
package khc_pkg;

  localparam int KMER_LENGTH = 6;
  localparam int COUNT_WIDTH = 16;
  localparam int BIN_BITS    = 2 * KMER_LENGTH;
  localparam int SUM_WIDTH   = 44;
  localparam int PROD_WIDTH  = 2 * SUM_WIDTH;
  localparam int CPROD_WIDTH = 2 * COUNT_WIDTH;
  localparam int SADD_WIDTH  = ((CPROD_WIDTH > SUM_WIDTH) ? CPROD_WIDTH : SUM_WIDTH) + 1;
  localparam int FRAC_BITS   = 16;
  localparam int SIM_WIDTH   = FRAC_BITS + 1;
  localparam int SRCH_WIDTH  = PROD_WIDTH + 2 * SIM_WIDTH;
  localparam int MUL_STEPS   = SUM_WIDTH;
  localparam int MCNT_WIDTH  = $clog2(MUL_STEPS);
  localparam int BIDX_WIDTH  = $clog2(SIM_WIDTH);

  // controller to datapath
  typedef struct packed {
    logic                capture;
    logic                inc;
    logic                walk;
    logic                clear;
    logic [BIN_BITS-1:0] addr;
    logic                acc_clear;
    logic                mul_start;
    logic                mul_step;
    logic                srch_start;
    logic                phase_a;
    logic                phase_b;
    logic [BIDX_WIDTH-1:0] bit_idx;
    logic                load;
  } khc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic empty;
    logic sim_top;
  } khc_status_t;

endpackage

### hdl/khc_datapath.sv
module khc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  khc_pkg::khc_cmd_t             cmd,
  output khc_pkg::khc_status_t          status,
  input  logic [11:0]                   minimizer_code,
  input  logic                          which_histogram,
  output logic [16:0]                   similarity,
  output logic                          empty_flag,
  output logic [43:0]                   dot_product,
  output logic [43:0]                   reference_square_sum,
  output logic [43:0]                   fragment_square_sum
);

  localparam int BB = khc_pkg::BIN_BITS;
  localparam int CW = khc_pkg::COUNT_WIDTH;
  localparam int SW = khc_pkg::SUM_WIDTH;
  localparam int PW = khc_pkg::PROD_WIDTH;
  localparam int CPW = khc_pkg::CPROD_WIDTH;
  localparam int AW = khc_pkg::SADD_WIDTH;
  localparam int XW = khc_pkg::SRCH_WIDTH;
  localparam int FB = khc_pkg::FRAC_BITS;
  localparam int SIW = khc_pkg::SIM_WIDTH;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
  localparam logic [AW-1:0] SUM_MAX = AW'({SW{1'b1}});

  // histogram memories
  logic [CW-1:0] ref_mem [2**BB];
  logic [CW-1:0] frag_mem [2**BB];
  logic [CW-1:0] ref_q;
  logic [CW-1:0] frag_q;
  logic [BB-1:0] bin_q;
  logic          which_q;
  logic [BB-1:0] rd_addr;
  logic [BB-1:0] wr_addr;
  logic          mem_rd;
  logic          ref_we;
  logic          frag_we;
  logic [CW-1:0] wr_data;
  logic [CW-1:0] cur_count;

  // walk pipeline
  logic           v1;
  logic           v2;
  logic [CPW-1:0] p_dot;
  logic [CPW-1:0] p_ref;
  logic [CPW-1:0] p_frag;
  logic [SW-1:0]  acc_dot;
  logic [SW-1:0]  acc_ref;
  logic [SW-1:0]  acc_frag;

  // shift-add multiplier
  logic [PW-1:0] y_prod;
  logic [PW-1:0] y_cand;
  logic [SW-1:0] y_plier;
  logic [PW-1:0] d_prod;
  logic [PW-1:0] d_cand;
  logic [SW-1:0] d_plier;

  // square root search
  logic [SIW-1:0] s_q;
  logic [XW-1:0]  p_q;
  logic [XW-1:0]  q_q;
  logic [XW-1:0]  t_q;
  logic [XW-1:0]  x_val;
  logic [XW-1:0]  y_ext;
  logic [XW-1:0]  trial;

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] acc,
                                            input logic [CPW-1:0] p);
    logic [AW-1:0] s;
    s = AW'(acc) + AW'(p);
    return (s > SUM_MAX) ? SW'(SUM_MAX) : SW'(s);
  endfunction

  // memory port selection
  assign rd_addr   = cmd.capture ? minimizer_code[BB-1:0] : cmd.addr;
  assign mem_rd    = cmd.capture || cmd.walk;
  assign wr_addr   = cmd.inc ? bin_q : cmd.addr;
  assign cur_count = which_q ? frag_q : ref_q;
  assign wr_data   = cmd.inc ? ((cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1)
                             : '0;
  assign ref_we    = cmd.walk || cmd.clear || (cmd.inc && !which_q);
  assign frag_we   = cmd.walk || cmd.clear || (cmd.inc && which_q);

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      ref_q  <= ref_mem[rd_addr];
      frag_q <= frag_mem[rd_addr];
    end
    if (ref_we) begin
      ref_mem[wr_addr] <= wr_data;
    end
    if (frag_we) begin
      frag_mem[wr_addr] <= wr_data;
    end
  end

  // latch the bin of the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bin_q   <= minimizer_code[BB-1:0];
      which_q <= which_histogram;
    end
  end

  // walk valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.walk;
      v2 <= v1;
    end
  end

  // products and saturating sums
  always_ff @(posedge clk) begin
    p_dot  <= CPW'(ref_q) * CPW'(frag_q);
    p_ref  <= CPW'(ref_q) * CPW'(ref_q);
    p_frag <= CPW'(frag_q) * CPW'(frag_q);
    if (cmd.acc_clear) begin
      acc_dot  <= '0;
      acc_ref  <= '0;
      acc_frag <= '0;
    end else if (v2) begin
      acc_dot  <= sat_add(acc_dot, p_dot);
      acc_ref  <= sat_add(acc_ref, p_ref);
      acc_frag <= sat_add(acc_frag, p_frag);
    end
  end

  // ref*frag sums product and dot squared, one bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      y_prod  <= '0;
      y_cand  <= PW'(acc_ref);
      y_plier <= acc_frag;
      d_prod  <= '0;
      d_cand  <= PW'(acc_dot);
      d_plier <= acc_dot;
    end else if (cmd.mul_step) begin
      if (y_plier[0]) begin
        y_prod <= y_prod + y_cand;
      end
      if (d_plier[0]) begin
        d_prod <= d_prod + d_cand;
      end
      y_cand  <= y_cand << 1;
      y_plier <= y_plier >> 1;
      d_cand  <= d_cand << 1;
      d_plier <= d_plier >> 1;
    end
  end

  // largest s with s*s*y <= d*d*2^32, each bit tried in phase a and then in phase b
  assign x_val = XW'(d_prod) << (2 * FB);
  assign y_ext = XW'(y_prod);
  assign trial = t_q + (y_ext << {cmd.bit_idx, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.srch_start) begin
      s_q <= '0;
      p_q <= '0;
      q_q <= '0;
    end else if (cmd.phase_a) begin
      t_q <= p_q + (q_q << (XW'(cmd.bit_idx) + XW'(1)));
    end else if (cmd.phase_b) begin
      if (trial <= x_val) begin
        s_q[cmd.bit_idx] <= 1'b1;
        p_q <= trial;
        q_q <= q_q + (y_ext << cmd.bit_idx);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      similarity           <= status.empty ? '0 : s_q;
      empty_flag           <= status.empty;
      dot_product          <= acc_dot;
      reference_square_sum <= acc_ref;
      fragment_square_sum  <= acc_frag;
    end
  end

  assign status.pipe_busy = v1 || v2;
  assign status.empty     = (acc_ref == '0) || (acc_frag == '0);
  assign status.sim_top   = s_q[SIW-1];

endmodule

### hdl/khc_controller.sv
`include "kmer_histogram_cosine_similarity_defines.svh"

module khc_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 code_valid,
  output logic                 code_stall,
  input  logic                 last,
  output logic                 result_valid,
  input  logic                 result_stall,
  output khc_pkg::khc_cmd_t    cmd,
  input  khc_pkg::khc_status_t status
);

  localparam int BB = khc_pkg::BIN_BITS;
  localparam int MW = khc_pkg::MCNT_WIDTH;
  localparam int IW = khc_pkg::BIDX_WIDTH;
  localparam logic [BB-1:0] ADDR_LAST = {BB{1'b1}};
  localparam logic [MW-1:0] MUL_LAST = MW'(khc_pkg::MUL_STEPS - 1);
  localparam logic [IW-1:0] BIT_TOP = IW'(khc_pkg::SIM_WIDTH - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_WALK,
    ST_DRAIN,
    ST_MUL,
    ST_PHASE_A,
    ST_PHASE_B,
    ST_FINISH
  } state_t;

  state_t        state;
  logic [BB-1:0] addr;
  logic [MW-1:0] mul_cnt;
  logic [IW-1:0] bit_idx;
  logic          last_q;
  logic          out_free;

  assign out_free   = !result_valid || !result_stall;
  assign code_stall = (state != ST_IDLE);

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      addr         <= '0;
      mul_cnt      <= '0;
      bit_idx      <= '0;
      last_q       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == ADDR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (code_valid) begin
            last_q <= last;
            state  <= ST_INC;
          end
        end
        ST_INC: begin
          state <= last_q ? ST_WALK : ST_IDLE;
        end
        ST_WALK: begin
          addr <= addr + 1'b1;
          if (addr == ADDR_LAST) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!status.pipe_busy) begin
            mul_cnt <= '0;
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          mul_cnt <= mul_cnt + 1'b1;
          if (mul_cnt == MUL_LAST) begin
            bit_idx <= BIT_TOP;
            state   <= status.empty ? ST_FINISH : ST_PHASE_A;
          end
        end
        ST_PHASE_A: begin
          state <= status.sim_top ? ST_FINISH : ST_PHASE_B;
        end
        ST_PHASE_B: begin
          if (bit_idx == '0) begin
            state <= ST_FINISH;
          end else begin
            bit_idx <= bit_idx - 1'b1;
            state   <= ST_PHASE_A;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd            = '0;
    cmd.addr       = addr;
    cmd.bit_idx    = bit_idx;
    cmd.capture    = (state == ST_IDLE) && code_valid;
    cmd.inc        = (state == ST_INC);
    cmd.walk       = (state == ST_WALK);
    cmd.clear      = (state == ST_CLEAR);
    cmd.acc_clear  = (state == ST_INC) && last_q;
    cmd.mul_start  = (state == ST_DRAIN) && !status.pipe_busy;
    cmd.mul_step   = (state == ST_MUL);
    cmd.srch_start = (state == ST_MUL) && (mul_cnt == MUL_LAST);
    cmd.phase_a    = (state == ST_PHASE_A) && !status.sim_top;
    cmd.phase_b    = (state == ST_PHASE_B);
    cmd.load       = (state == ST_FINISH) && out_free;
  end

  `KHC_ASSERT_ALWAYS(a_no_walk_during_count, !(cmd.walk && cmd.inc))
  `KHC_ASSERT_NEXT(a_load_gives_result, cmd.load, result_valid)
  `KHC_ASSERT_ALWAYS(a_mul_count_range, !cmd.mul_step || (mul_cnt <= MUL_LAST))
  `KHC_ASSERT_ALWAYS(a_bit_range, !(cmd.phase_a || cmd.phase_b) || (bit_idx <= BIT_TOP))

endmodule

### hdl/kmer_histogram_cosine_similarity.sv
// channel  | valid        | stall        | payload
// code     | code_valid   | code_stall   | minimizer_code, which_histogram, last
// result   | result_valid | result_stall | similarity, empty_flag, dot_product,
//          |              |              | reference_square_sum, fragment_square_sum
//
// a code transaction reads the bin, then writes the saturated count
// a last code adds a walk over all 4096 bins (one bin per cycle), a drain of the walk
//   pipeline, a shift-add multiply over the 44 multiplier bits, and a square root bit search of up to 17 bits
// after reset a clearing pass over all 4096 bins runs before the first code is taken
// the result register lets counting go on while a result waits; a new result waits
//   for that register to empty
module kmer_histogram_cosine_similarity (
  input  logic        clk,
  input  logic        rst,
  input  logic        code_valid,
  output logic        code_stall,
  input  logic [11:0] minimizer_code,
  input  logic        which_histogram,
  input  logic        last,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [16:0] similarity,
  output logic        empty_flag,
  output logic [43:0] dot_product,
  output logic [43:0] reference_square_sum,
  output logic [43:0] fragment_square_sum
);

  khc_pkg::khc_cmd_t    cmd;
  khc_pkg::khc_status_t status;

  // sequencing
  khc_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  // histograms and arithmetic
  khc_datapath u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .minimizer_code       (minimizer_code),
    .which_histogram      (which_histogram),
    .similarity           (similarity),
    .empty_flag           (empty_flag),
    .dot_product          (dot_product),
    .reference_square_sum (reference_square_sum),
    .fragment_square_sum  (fragment_square_sum)
  );

endmodule

### tb/tb_kmer_histogram_cosine_similarity.sv
`timescale 1ns / 1ps

module tb_kmer_histogram_cosine_similarity;

  localparam int BINS = 1 << khc_pkg::BIN_BITS;
  localparam logic [khc_pkg::COUNT_WIDTH-1:0] COUNT_TOP = '1;
  localparam logic [khc_pkg::SUM_WIDTH-1:0] SUM_TOP = '1;
  localparam int UNITY = 1 << khc_pkg::FRAC_BITS;
  localparam logic REF_SIDE = 1'b0;
  localparam logic FRAG_SIDE = 1'b1;

  typedef struct {
    logic [16:0] score;
    logic        empty;
    logic [43:0] dot;
    logic [43:0] ref_sq;
    logic [43:0] frag_sq;
  } cosine_t;

  // histogram tracker: counts codes and predicts the comparison on a last code
  class kmer_cosine_tracker;
    logic [khc_pkg::COUNT_WIDTH-1:0] ref_bins[BINS];
    logic [khc_pkg::COUNT_WIDTH-1:0] frag_bins[BINS];
    cosine_t pending_scores[$];
    int errors;

    function new();
      clear_bins();
      errors = 0;
    endfunction

    function void clear_bins();
      foreach (ref_bins[i]) begin
        ref_bins[i] = '0;
        frag_bins[i] = '0;
      end
    endfunction

    function logic [43:0] sat_sum(logic [43:0] acc, logic [47:0] p);
      logic [63:0] s;
      s = 64'(acc) + 64'(p);
      return (s > 64'(SUM_TOP)) ? SUM_TOP : s[43:0];
    endfunction

    // largest q in [0, 1.0] with q^2 * a * b <= 2^32 * d^2
    function logic [16:0] cosine_q16(logic [43:0] d, logic [43:0] a, logic [43:0] b);
      logic [127:0] ab, rhs, lhs, m2;
      int lo, hi, mid;
      ab = 128'(a) * 128'(b);
      rhs = (128'(d) * 128'(d)) << 32;
      lo = 0;
      hi = UNITY;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        m2 = 128'(mid) * 128'(mid);
        lhs = ab * m2;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return 17'(lo);
    endfunction

    // note an accepted code transaction
    function void note_code(logic [11:0] code, logic side, logic lst);
      logic [khc_pkg::BIN_BITS-1:0] bin;
      logic [khc_pkg::COUNT_WIDTH-1:0] r, f;
      cosine_t e;
      bin = code[khc_pkg::BIN_BITS-1:0];
      if (side == FRAG_SIDE) begin
        if (frag_bins[bin] != COUNT_TOP) frag_bins[bin]++;
      end else begin
        if (ref_bins[bin] != COUNT_TOP) ref_bins[bin]++;
      end
      if (!lst) return;
      e.dot = '0;
      e.ref_sq = '0;
      e.frag_sq = '0;
      for (int i = 0; i < BINS; i++) begin
        r = ref_bins[i];
        f = frag_bins[i];
        e.dot = sat_sum(e.dot, 48'(r) * 48'(f));
        e.ref_sq = sat_sum(e.ref_sq, 48'(r) * 48'(r));
        e.frag_sq = sat_sum(e.frag_sq, 48'(f) * 48'(f));
      end
      e.empty = (e.ref_sq == 0) || (e.frag_sq == 0);
      e.score = e.empty ? 17'd0 : cosine_q16(e.dot, e.ref_sq, e.frag_sq);
      pending_scores.insert(pending_scores.size(), e);
      clear_bins();
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    // check a result transaction against the oldest prediction
    task check_result(cosine_t got);
      cosine_t w;
      if (pending_scores.size() == 0) begin
        report("unexpected result", 64'(got.score), 0);
        return;
      end
      w = pending_scores.pop_front();
      if (got.score !== w.score) report("similarity", 64'(got.score), 64'(w.score));
      if (got.empty !== w.empty) report("empty_flag", 64'(got.empty), 64'(w.empty));
      if (got.dot !== w.dot) report("dot_product", 64'(got.dot), 64'(w.dot));
      if (got.ref_sq !== w.ref_sq) report("reference_square_sum", 64'(got.ref_sq), 64'(w.ref_sq));
      if (got.frag_sq !== w.frag_sq) report("fragment_square_sum", 64'(got.frag_sq), 64'(w.frag_sq));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic code_valid = 1'b0;
  logic code_stall;
  logic [11:0] minimizer_code = '0;
  logic which_histogram = 1'b0;
  logic last = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [16:0] similarity;
  logic empty_flag;
  logic [43:0] dot_product;
  logic [43:0] reference_square_sum;
  logic [43:0] fragment_square_sum;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  kmer_cosine_tracker tracker = new();

  kmer_histogram_cosine_similarity i_dut (
    .clk(clk), .rst(rst),
    .code_valid(code_valid), .code_stall(code_stall),
    .minimizer_code(minimizer_code), .which_histogram(which_histogram), .last(last),
    .result_valid(result_valid), .result_stall(result_stall),
    .similarity(similarity), .empty_flag(empty_flag), .dot_product(dot_product),
    .reference_square_sum(reference_square_sum), .fragment_square_sum(fragment_square_sum)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watch both channels for transactions
  always @(posedge clk) begin
    cosine_t got;
    if (!rst && code_valid && !code_stall)
      tracker.note_code(minimizer_code, which_histogram, last);
    if (!rst && result_valid && !result_stall) begin
      got.score = similarity;
      got.empty = empty_flag;
      got.dot = dot_product;
      got.ref_sq = reference_square_sum;
      got.frag_sq = fragment_square_sum;
      tracker.check_result(got);
    end
  end

  // one code transaction, with random idle cycles ahead of it
  task send_code(logic [11:0] code, logic side, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      code_valid <= 1'b0;
      @(posedge clk);
    end
    code_valid <= 1'b1;
    minimizer_code <= code;
    which_histogram <= side;
    last <= lst;
    @(posedge clk);
    while (code_stall) @(posedge clk);
  endtask

  task send_random(int count);
    logic [11:0] code;
    logic [11:0] base;
    base = 12'($urandom);
    for (int n = 0; n < count; n++) begin
      // mostly codes clustered near a base so bins are shared, some spread wide
      if ($urandom_range(99) < 70) code = base + 12'($urandom_range(0, 23));
      else code = 12'($urandom);
      send_code(code, 1'($urandom), ($urandom_range(29) == 0));
      if ($urandom_range(199) == 0) base = 12'($urandom);
    end
  endtask

  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reference only, so the fragment side is empty
    send_code(12'd0, REF_SIDE, 1'b1);
    // fragment only
    send_code(12'hFFF, FRAG_SIDE, 1'b1);
    // identical histograms give exactly one
    send_code(12'd0, REF_SIDE, 1'b0);
    send_code(12'hFFF, REF_SIDE, 1'b0);
    send_code(12'd0, FRAG_SIDE, 1'b0);
    send_code(12'hFFF, FRAG_SIDE, 1'b1);
    // disjoint histograms give zero
    send_code(12'h555, REF_SIDE, 1'b0);
    send_code(12'hAAA, FRAG_SIDE, 1'b1);
    // partial overlap
    send_code(12'h123, REF_SIDE, 1'b0);
    send_code(12'h123, REF_SIDE, 1'b0);
    send_code(12'h456, REF_SIDE, 1'b0);
    send_code(12'h123, FRAG_SIDE, 1'b0);
    send_code(12'h789, FRAG_SIDE, 1'b1);
    // one bin counted many times on the reference side
    for (int n = 0; n < 8; n++) send_code(12'h3C3, REF_SIDE, 1'b0);
    send_code(12'h3C3, FRAG_SIDE, 1'b0);
    send_code(12'h001, FRAG_SIDE, 1'b1);

    // random phases with varying idle and stall
    send_idle_pct = 27;
    recv_stall_pct = 61;
    send_random(580);
    send_code(12'($urandom), 1'($urandom), 1'b1);
    send_idle_pct = 61;
    recv_stall_pct = 27;
    send_random(580);
    send_code(12'($urandom), 1'($urandom), 1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(580);
    send_code(12'($urandom), 1'($urandom), 1'b1);
    code_valid <= 1'b0;

    // drain outstanding results
    waited = 0;
    while (tracker.pending_scores.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (5000) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_scores.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
